// ===== rtl/scrf_pkg.sv =====
`default_nettype none

package scrf_pkg;

  // opcodes of an input transaction
  localparam logic [2:0] OP_SEND  = 3'd0;
  localparam logic [2:0] OP_CRC   = 3'd1;
  localparam logic [2:0] OP_READ  = 3'd2;
  localparam logic [2:0] OP_RX    = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;

  // reply forms
  localparam logic [1:0] FORM_TWO    = 2'd0;
  localparam logic [1:0] FORM_FOUR   = 2'd1;
  localparam logic [1:0] FORM_STATUS = 2'd2;
  localparam logic [1:0] FORM_ALIAS  = 2'd3;

  // config register indexes
  localparam logic [1:0] CFG_ADDR    = 2'd0;
  localparam logic [1:0] CFG_RETRY   = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [7:0]  ADDR_RST    = 8'd128;
  localparam logic [3:0]  RETRY_RST   = 4'd0;
  localparam logic [15:0] TIMEOUT_RST = 16'd10000;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // result queue geometry
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  typedef struct packed {
    logic [7:0]  device_address;
    logic [3:0]  retry_limit;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic       first_of_frame;
    logic [1:0] reply_form;
  } item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        reply_done;
    logic        reply_ok;
    logic [31:0] reply_value;
    logic [7:0]  reply_status;
    logic        last;
  } result_t;

  // CRC-16/XMODEM, one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/scrf_core.sv =====
`default_nettype none

module scrf_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire scrf_pkg::cfg_t   cfg,
  input  wire scrf_pkg::item_t  item,
  input  wire logic             fire,
  output scrf_pkg::result_t     res0,
  output scrf_pkg::result_t     res1,
  output logic [1:0]            res_cnt
);

  logic [15:0] crc_r,    crc_nxt;
  logic        pend_r,   pend_nxt;
  logic [2:0]  nrx_r,    nrx_nxt;
  logic [31:0] acc_r,    acc_nxt;
  logic [7:0]  stat_r,   stat_nxt;
  logic [7:0]  crch_r,   crch_nxt;
  logic [3:0]  retry_r,  retry_nxt;
  logic [15:0] wait_r,   wait_nxt;
  logic [7:0]  cmd_r,    cmd_nxt;
  logic [1:0]  form_r,   form_nxt;

  logic [7:0]  req_cmd;
  logic [15:0] req_crc;
  logic [2:0]  rx_len;
  logic [15:0] wait_inc;
  logic        do_req;
  logic        do_fail;

  assign req_cmd  = (item.opcode == scrf_pkg::OP_READ) ? item.data_byte : cmd_r;
  assign req_crc  = scrf_pkg::crc_byte(scrf_pkg::crc_byte(16'h0000, cfg.device_address),
                                       req_cmd);
  assign rx_len   = (form_r == scrf_pkg::FORM_TWO)  ? 3'd2 :
                    (form_r == scrf_pkg::FORM_FOUR) ? 3'd4 : 3'd5;
  assign wait_inc = wait_r + 16'd1;

  always_comb begin
    crc_nxt   = crc_r;
    pend_nxt  = pend_r;
    nrx_nxt   = nrx_r;
    acc_nxt   = acc_r;
    stat_nxt  = stat_r;
    crch_nxt  = crch_r;
    retry_nxt = retry_r;
    wait_nxt  = wait_r;
    cmd_nxt   = cmd_r;
    form_nxt  = form_r;
    res0      = '0;
    res1      = '0;
    res_cnt   = 2'd0;
    do_req    = 1'b0;
    do_fail   = 1'b0;

    unique case (item.opcode)
      scrf_pkg::OP_SEND: begin
        crc_nxt = scrf_pkg::crc_byte(item.first_of_frame ? 16'h0000 : crc_r,
                                     item.data_byte);
        res0.tx_valid = 1'b1;
        res0.tx_byte  = item.data_byte;
        res0.last     = 1'b1;
        res_cnt       = 2'd1;
      end
      scrf_pkg::OP_CRC: begin
        res0.tx_valid = 1'b1;
        res0.tx_byte  = crc_r[15:8];
        res1.tx_valid = 1'b1;
        res1.tx_byte  = crc_r[7:0];
        res1.last     = 1'b1;
        res_cnt       = 2'd2;
      end
      scrf_pkg::OP_READ: begin
        cmd_nxt   = item.data_byte;
        form_nxt  = (item.reply_form == scrf_pkg::FORM_ALIAS) ? scrf_pkg::FORM_STATUS
                                                               : item.reply_form;
        retry_nxt = cfg.retry_limit;
        do_req    = 1'b1;
      end
      scrf_pkg::OP_RX: begin
        if (pend_r) begin
          wait_nxt = 16'h0000;
          if (nrx_r < rx_len) begin
            crc_nxt = scrf_pkg::crc_byte(crc_r, item.data_byte);
            if (nrx_r < 3'd4) begin
              acc_nxt = {acc_r[23:0], item.data_byte};
            end else begin
              stat_nxt = item.data_byte;
            end
            nrx_nxt = nrx_r + 3'd1;
          end else if (nrx_r == rx_len) begin
            crch_nxt = item.data_byte;
            nrx_nxt  = nrx_r + 3'd1;
          end else if ({crch_r, item.data_byte} == crc_r) begin
            pend_nxt          = 1'b0;
            nrx_nxt           = 3'd0;
            res0.reply_done   = 1'b1;
            res0.reply_ok     = 1'b1;
            res0.reply_value  = acc_r;
            res0.reply_status = (form_r == scrf_pkg::FORM_STATUS) ? stat_r : 8'h00;
            res0.last         = 1'b1;
            res_cnt           = 2'd1;
          end else begin
            do_fail = 1'b1;
          end
        end
      end
      scrf_pkg::OP_TICK: begin
        if (pend_r) begin
          wait_nxt = wait_inc;
          if (wait_inc >= cfg.timeout_ticks) begin
            do_fail = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (do_fail) begin
      if (retry_r != 4'd0) begin
        retry_nxt = retry_r - 4'd1;
        do_req    = 1'b1;
      end else begin
        pend_nxt        = 1'b0;
        nrx_nxt         = 3'd0;
        wait_nxt        = 16'h0000;
        res0.reply_done = 1'b1;
        res0.last       = 1'b1;
        res_cnt         = 2'd1;
      end
    end

    if (do_req) begin
      crc_nxt       = req_crc;
      nrx_nxt       = 3'd0;
      acc_nxt       = 32'h0;
      stat_nxt      = 8'h00;
      crch_nxt      = 8'h00;
      wait_nxt      = 16'h0000;
      pend_nxt      = 1'b1;
      res0          = '0;
      res0.tx_valid = 1'b1;
      res0.tx_byte  = cfg.device_address;
      res1          = '0;
      res1.tx_valid = 1'b1;
      res1.tx_byte  = req_cmd;
      res1.last     = 1'b1;
      res_cnt       = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= '0;
      pend_r  <= 1'b0;
      nrx_r   <= '0;
      acc_r   <= '0;
      stat_r  <= '0;
      crch_r  <= '0;
      retry_r <= '0;
      wait_r  <= '0;
      cmd_r   <= '0;
      form_r  <= '0;
    end else if (fire) begin
      crc_r   <= crc_nxt;
      pend_r  <= pend_nxt;
      nrx_r   <= nrx_nxt;
      acc_r   <= acc_nxt;
      stat_r  <= stat_nxt;
      crch_r  <= crch_nxt;
      retry_r <= retry_nxt;
      wait_r  <= wait_nxt;
      cmd_r   <= cmd_nxt;
      form_r  <= form_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/scrf_outq.sv =====
`default_nettype none

module scrf_outq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [1:0]         push_cnt,
  input  wire scrf_pkg::result_t  push0,
  input  wire scrf_pkg::result_t  push1,
  input  wire logic               pop,
  output scrf_pkg::result_t       head,
  output logic                    head_valid,
  output logic                    has_room,
  output logic [scrf_pkg::QCW-1:0] count
);

  localparam int AW = scrf_pkg::QAW;
  localparam int CW = scrf_pkg::QCW;

  scrf_pkg::result_t mem [scrf_pkg::QDEPTH];

  logic [AW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt, wptr_p1;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign wptr_p1    = wptr_r + AW'(1);
  assign wptr_nxt   = wptr_r + AW'(push_cnt);
  assign rptr_nxt   = rptr_r + AW'(pop);
  assign cnt_nxt    = cnt_r + CW'(push_cnt) - CW'(pop);
  // room for a full two-result push
  assign has_room   = (cnt_r <= CW'(scrf_pkg::QDEPTH - 2));
  assign head_valid = (cnt_r != '0);
  assign head       = mem[rptr_r];
  assign count      = cnt_r;

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wptr_p1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/serial_command_reply_framer.sv =====
`default_nettype none

// Serial command/reply framer with CRC-16/XMODEM (poly 0x1021, init 0).
// Each input transaction is one opcode: send byte, append CRC (high then low),
// read request (address + command out, then collect the reply), received byte,
// or timer tick. Results leave on the out_ channel, one per transaction, with
// out_last marking the final result of an input; a transaction gives zero, one
// or two results. Timing: an accepted input waits in the input register
// until the queue has room, is processed in a single pass into a
// four-entry result queue, and its first result is offered the next cycle.
// One input is taken every cycle as long as the queue holds at most two
// results; the queue depth, drained one result per pop, is what limits a
// run of two-result inputs under a stalled output. Config writes (cfg_we)
// take effect the next cycle and are meant to be done while the block is idle.
module serial_command_reply_framer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_first_of_frame,
  input  wire logic [1:0]  in_reply_form,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_tx_valid,
  output logic [7:0]       out_tx_byte,
  output logic             out_reply_done,
  output logic             out_reply_ok,
  output logic [31:0]      out_reply_value,
  output logic [7:0]       out_reply_status,
  output logic             out_last,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  scrf_pkg::cfg_t    cfg_r;
  scrf_pkg::item_t   item_r;
  logic              hold_r;
  logic              adv;
  logic              q_room;
  logic              q_valid;
  logic [scrf_pkg::QCW-1:0] q_count;
  scrf_pkg::result_t res0, res1, head;
  logic [1:0]        res_cnt;
  logic [1:0]        push_cnt;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address <= scrf_pkg::ADDR_RST;
      cfg_r.retry_limit    <= scrf_pkg::RETRY_RST;
      cfg_r.timeout_ticks  <= scrf_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scrf_pkg::CFG_ADDR:    cfg_r.device_address <= cfg_wdata[7:0];
        scrf_pkg::CFG_RETRY:   cfg_r.retry_limit    <= cfg_wdata[3:0];
        scrf_pkg::CFG_TIMEOUT: cfg_r.timeout_ticks  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input register: the held transaction moves on once the queue has room
  assign adv      = hold_r && q_room;
  assign in_ready = !hold_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_r <= 1'b1;
    end else if (adv) begin
      hold_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.opcode         <= in_opcode;
      item_r.data_byte      <= in_data_byte;
      item_r.first_of_frame <= in_first_of_frame;
      item_r.reply_form     <= in_reply_form;
    end
  end

  // framing state and result generation
  scrf_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .item    (item_r),
    .fire    (adv),
    .res0    (res0),
    .res1    (res1),
    .res_cnt (res_cnt)
  );

  assign push_cnt = adv ? res_cnt : 2'd0;

  // result queue
  scrf_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .push0      (res0),
    .push1      (res1),
    .pop        (out_valid && out_ready),
    .head       (head),
    .head_valid (q_valid),
    .has_room   (q_room),
    .count      (q_count)
  );

  assign out_valid        = q_valid;
  assign out_tx_valid     = head.tx_valid;
  assign out_tx_byte      = head.tx_byte;
  assign out_reply_done   = head.reply_done;
  assign out_reply_ok     = head.reply_ok;
  assign out_reply_value  = head.reply_value;
  assign out_reply_status = head.reply_status;
  assign out_last         = head.last;

  // queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= scrf_pkg::QCW'(scrf_pkg::QDEPTH))
    else $error("result queue overflow");

  // a finished read carries no transmit byte and closes its input
  a_done_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reply_done) |-> (!out_tx_valid && out_last))
    else $error("done result malformed");

  // a failed reply reports zero value and status
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reply_done && !out_reply_ok) |->
      (out_reply_value == 32'h0 && out_reply_status == 8'h00))
    else $error("failed reply carries data");

  // input is only back-pressured while a transaction waits for queue room
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (hold_r && !q_room))
    else $error("unexpected input stall");

endmodule

`default_nettype wire

// ===== bench/serial_command_reply_framer_tb.sv =====
`timescale 1ns / 100ps

module serial_command_reply_framer_tb;

  // opcodes the block must ignore
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 150;
  localparam int SETTLE_CYCLES = 6;    // input register + result queue, with margin
  localparam int MAX_ATTEMPTS  = 4;    // most reply attempts per request, even under a larger retry limit

  // Expected-result tracker: mirrors the framer state, queues the results each
  // accepted input transaction should produce and checks them in order.
  class framer_scoreboard;
    // config copy
    logic [7:0]  dev_addr;
    logic [3:0]  retry_lim;
    logic [15:0] tmo_ticks;
    // block state
    logic [15:0] crc;
    logic        pending;
    logic [2:0]  nrx;
    logic [31:0] acc;
    logic [7:0]  stat;
    logic [7:0]  crc_hi;
    logic [3:0]  retries;
    logic [15:0] waited;
    logic [7:0]  cmd;
    logic [1:0]  form;

    scrf_pkg::result_t due_results[$];
    int      fails;

    function void clear_state();
      dev_addr  = scrf_pkg::ADDR_RST;
      retry_lim = scrf_pkg::RETRY_RST;
      tmo_ticks = scrf_pkg::TIMEOUT_RST;
      crc       = '0;
      pending   = 1'b0;
      nrx       = '0;
      acc       = '0;
      stat      = '0;
      crc_hi    = '0;
      retries   = '0;
      waited    = '0;
      cmd       = '0;
      form      = scrf_pkg::FORM_TWO;
      fails     = 0;
      due_results.delete();
    endfunction

    // CRC-16/XMODEM, one byte, MSB first
    function logic [15:0] crc16_step(logic [15:0] c_in, logic [7:0] b);
      logic [15:0] c;
      c = c_in ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
        c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      end
      return c;
    endfunction

    function void apply_cfg(logic [1:0] idx, logic [15:0] v);
      case (idx)
        scrf_pkg::CFG_ADDR:    dev_addr  = v[7:0];
        scrf_pkg::CFG_RETRY:   retry_lim = v[3:0];
        scrf_pkg::CFG_TIMEOUT: tmo_ticks = v;
        default: ;
      endcase
    endfunction

    function void queue_tx(logic [7:0] b, logic lst);
      scrf_pkg::result_t r;
      r          = '0;
      r.tx_valid = 1'b1;
      r.tx_byte  = b;
      r.last     = lst;
      due_results.push_back(r);
    endfunction

    function void queue_done(logic ok, logic [31:0] val, logic [7:0] st);
      scrf_pkg::result_t r;
      r              = '0;
      r.reply_done   = 1'b1;
      r.reply_ok     = ok;
      r.reply_value  = val;
      r.reply_status = st;
      r.last         = 1'b1;
      due_results.push_back(r);
    endfunction

    // address + command out, CRC seeded over both
    function void start_attempt();
      crc     = crc16_step(crc16_step(16'h0000, dev_addr), cmd);
      nrx     = '0;
      acc     = '0;
      stat    = '0;
      crc_hi  = '0;
      waited  = '0;
      pending = 1'b1;
      queue_tx(dev_addr, 1'b0);
      queue_tx(cmd, 1'b1);
    endfunction

    function void attempt_failed();
      if (retries != 0) begin
        retries = retries - 4'd1;
        start_attempt();
      end else begin
        pending = 1'b0;
        nrx     = '0;
        waited  = '0;
        queue_done(1'b0, '0, '0);
      end
    endfunction

    function void note_item(scrf_pkg::item_t it);
      int need;
      case (it.opcode)
        scrf_pkg::OP_SEND: begin
          if (it.first_of_frame) crc = '0;
          crc = crc16_step(crc, it.data_byte);
          queue_tx(it.data_byte, 1'b1);
        end
        scrf_pkg::OP_CRC: begin
          queue_tx(crc[15:8], 1'b0);
          queue_tx(crc[7:0], 1'b1);
        end
        scrf_pkg::OP_READ: begin
          cmd     = it.data_byte;
          form    = (it.reply_form == scrf_pkg::FORM_ALIAS) ? scrf_pkg::FORM_STATUS
                                                            : it.reply_form;
          retries = retry_lim;
          start_attempt();
        end
        scrf_pkg::OP_RX: begin
          if (pending) begin
            need   = (form == scrf_pkg::FORM_TWO) ? 2 :
                     (form == scrf_pkg::FORM_FOUR) ? 4 : 5;
            waited = '0;
            if (nrx < need) begin
              crc = crc16_step(crc, it.data_byte);
              if (nrx < 4) acc = {acc[23:0], it.data_byte};
              else stat = it.data_byte;
              nrx = nrx + 3'd1;
            end else if (nrx == need) begin
              crc_hi = it.data_byte;
              nrx    = nrx + 3'd1;
            end else if ({crc_hi, it.data_byte} == crc) begin
              pending = 1'b0;
              nrx     = '0;
              queue_done(1'b1, acc, (form == scrf_pkg::FORM_STATUS) ? stat : 8'h00);
            end else begin
              attempt_failed();
            end
          end
        end
        scrf_pkg::OP_TICK: begin
          if (pending) begin
            waited = waited + 16'd1;
            if (waited >= tmo_ticks) attempt_failed();
          end
        end
        default: ;  // spare opcodes do nothing
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, seen);
        fails++;
      end
    endfunction

    function void check_result(scrf_pkg::result_t got);
      scrf_pkg::result_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing expected: %p", got);
        fails++;
        return;
      end
      want = due_results.pop_front();
      compare_field("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
      compare_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
      compare_field("reply_done", 32'(want.reply_done), 32'(got.reply_done));
      compare_field("reply_ok", 32'(want.reply_ok), 32'(got.reply_ok));
      compare_field("reply_value", want.reply_value, got.reply_value);
      compare_field("reply_status", 32'(want.reply_status), 32'(got.reply_status));
      compare_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic        clk;
  logic        rst_n             = 1'b0;
  logic        in_valid          = 1'b0;
  logic        in_ready;
  logic [2:0]  in_opcode         = scrf_pkg::OP_SEND;
  logic [7:0]  in_data_byte      = '0;
  logic        in_first_of_frame = 1'b0;
  logic [1:0]  in_reply_form     = scrf_pkg::FORM_TWO;
  logic        out_valid;
  logic        out_ready         = 1'b0;
  logic        out_tx_valid;
  logic [7:0]  out_tx_byte;
  logic        out_reply_done;
  logic        out_reply_ok;
  logic [31:0] out_reply_value;
  logic [7:0]  out_reply_status;
  logic        out_last;
  logic        cfg_we            = 1'b0;
  logic [1:0]  cfg_index         = scrf_pkg::CFG_ADDR;
  logic [15:0] cfg_wdata         = '0;

  framer_scoreboard sb;

  // idle percentages of the two sides, changed between phases
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // count of meaningful (opcode 0..4) transactions sent
  int items_sent    = 0;
  int cycle_count   = 0;

  // tb-side copy of the config, used to build well-formed replies
  logic [7:0]  cur_addr  = scrf_pkg::ADDR_RST;
  logic [3:0]  cur_retry = scrf_pkg::RETRY_RST;
  logic [15:0] cur_tmo   = scrf_pkg::TIMEOUT_RST;

  serial_command_reply_framer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_data_byte      (in_data_byte),
    .in_first_of_frame (in_first_of_frame),
    .in_reply_form     (in_reply_form),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_tx_valid      (out_tx_valid),
    .out_tx_byte       (out_tx_byte),
    .out_reply_done    (out_reply_done),
    .out_reply_ok      (out_reply_ok),
    .out_reply_value   (out_reply_value),
    .out_reply_status  (out_reply_status),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver side: random back-pressure, re-rolled every falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result monitor: values read right after the edge are the pre-edge ones.
  always @(posedge clk) begin : result_mon
    scrf_pkg::result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.tx_valid     = out_tx_valid;
      got.tx_byte      = out_tx_byte;
      got.reply_done   = out_reply_done;
      got.reply_ok     = out_reply_ok;
      got.reply_value  = out_reply_value;
      got.reply_status = out_reply_status;
      got.last         = out_last;
      sb.check_result(got);
    end
  end

  // One input transaction. Entered and left on a falling edge; valid stays
  // high across back-to-back transactions, dropping only for a random gap.
  task automatic push_item(input logic [2:0] op, input logic [7:0] b,
                           input logic f, input logic [1:0] rf);
    scrf_pkg::item_t it;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    it.opcode         = op;
    it.data_byte      = b;
    it.first_of_frame = f;
    it.reply_form     = rf;
    in_valid          <= 1'b1;
    in_opcode         <= op;
    in_data_byte      <= b;
    in_first_of_frame <= f;
    in_reply_form     <= rf;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    if (op <= scrf_pkg::OP_TICK) items_sent++;
    @(negedge clk);
  endtask

  // Random opcode-independent fields for a transaction.
  task automatic push_rand(input logic [2:0] op, input logic [7:0] b);
    push_item(op, b, 1'($urandom_range(1)), 2'($urandom_range(3)));
  endtask

  // Write all three registers on consecutive cycles; block must be idle.
  task automatic set_config(input logic [7:0] addr, input logic [3:0] retry,
                            input logic [15:0] tmo);
    logic [1:0]  idx [3];
    logic [15:0] val [3];
    idx = '{scrf_pkg::CFG_ADDR, scrf_pkg::CFG_RETRY, scrf_pkg::CFG_TIMEOUT};
    val = '{{8'h00, addr}, {12'h000, retry}, tmo};
    for (int k = 0; k < 3; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= val[k];
      @(posedge clk);
      sb.apply_cfg(idx[k], val[k]);
      @(negedge clk);
    end
    cfg_we    <= 1'b0;
    cur_addr  = addr;
    cur_retry = retry;
    cur_tmo   = tmo;
  endtask

  // Stop sending, let every expected result drain, then cover transactions
  // that produce nothing but may still be in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Reply bytes for the current request, CRC over address, command and data.
  // A corrupted reply flips one CRC bit.
  task automatic send_reply(input logic [7:0] cmd, input logic [1:0] rf, input bit corrupt);
    logic [15:0] c;
    logic [7:0]  d;
    int          n;
    n = (rf == scrf_pkg::FORM_TWO) ? 2 : (rf == scrf_pkg::FORM_FOUR) ? 4 : 5;
    c = sb.crc16_step(sb.crc16_step(16'h0000, cur_addr), cmd);
    for (int k = 0; k < n; k++) begin
      d = 8'($urandom);
      c = sb.crc16_step(c, d);
      // stray tick between bytes, only where it cannot time the reply out
      if (cur_tmo >= 3 && $urandom_range(99) < 8)
        push_rand(scrf_pkg::OP_TICK, 8'($urandom));
      push_rand(scrf_pkg::OP_RX, d);
    end
    if (corrupt) c = c ^ (16'h0001 << $urandom_range(15));
    push_rand(scrf_pkg::OP_RX, c[15:8]);
    push_rand(scrf_pkg::OP_RX, c[7:0]);
  endtask

  // Request plus a run of attempts: good reply, bad CRC, or silence until
  // the timeout fires. Attempts past MAX_ATTEMPTS go to the next request.
  task automatic read_exchange();
    logic [7:0] cmd;
    logic [1:0] rf;
    int         attempts;
    int         pick;
    cmd = 8'($urandom);
    rf  = 2'($urandom_range(3));
    push_item(scrf_pkg::OP_READ, cmd, 1'($urandom_range(1)), rf);
    attempts = (cur_retry + 1 > MAX_ATTEMPTS) ? MAX_ATTEMPTS : cur_retry + 1;
    for (int a = 0; a < attempts; a++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        send_reply(cmd, rf, 1'b0);
        break;
      end else if (pick < 75 || cur_tmo > 40) begin
        send_reply(cmd, rf, 1'b1);
      end else begin
        repeat ($urandom_range(2))
          push_rand(scrf_pkg::OP_RX, 8'($urandom));
        repeat ((cur_tmo == 0) ? 1 : cur_tmo)
          push_rand(scrf_pkg::OP_TICK, 8'($urandom));
      end
    end
  endtask

  // Outgoing frame: bytes, then the CRC trailer.
  task automatic send_frame();
    int len;
    len = $urandom_range(6, 1);
    for (int k = 0; k < len; k++)
      push_item(scrf_pkg::OP_SEND, 8'($urandom),
                (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(9) == 0),
                2'($urandom_range(3)));
    push_rand(scrf_pkg::OP_CRC, 8'($urandom));
  endtask

  task automatic random_sequence();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      read_exchange();
    end else if (pick < 65) begin
      send_frame();
    end else if (pick < 80) begin
      // noise: any opcode, any field values
      repeat ($urandom_range(3, 1))
        push_rand(3'($urandom_range(7)), 8'($urandom));
    end else if (pick < 90) begin
      // request abandoned part way, replaced by a new one
      push_rand(scrf_pkg::OP_READ, 8'($urandom));
      repeat ($urandom_range(3))
        push_rand(scrf_pkg::OP_RX, 8'($urandom));
      read_exchange();
    end else begin
      // stray ticks and bytes, usually with nothing pending
      repeat ($urandom_range(3, 1))
        push_rand($urandom_range(1) ? scrf_pkg::OP_TICK : scrf_pkg::OP_RX, 8'($urandom));
    end
  endtask

  initial begin
    logic [15:0] c;
    logic [7:0]  d;
    sb = new;
    sb.clear_state();

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 33;
    recv_idle_pct = 45;

    // ---- directed part ----
    set_config(8'h5A, 4'd1, 16'd2);

    // frame with extreme bytes, then its CRC trailer
    push_item(scrf_pkg::OP_SEND, 8'h00, 1'b1, scrf_pkg::FORM_TWO);
    push_item(scrf_pkg::OP_SEND, 8'hFF, 1'b0, scrf_pkg::FORM_ALIAS);
    push_item(scrf_pkg::OP_CRC, 8'h00, 1'b0, scrf_pkg::FORM_TWO);

    // byte and tick with no read pending: dropped
    push_item(scrf_pkg::OP_RX, 8'h55, 1'b0, scrf_pkg::FORM_TWO);
    push_item(scrf_pkg::OP_TICK, 8'hAA, 1'b1, scrf_pkg::FORM_TWO);

    // spare opcodes: ignored
    for (int k = OP_SPARE_LO; k <= OP_SPARE_HI; k++)
      push_rand(3'(k), 8'($urandom));

    // reply form three acts as four plus status; good CRC
    push_item(scrf_pkg::OP_READ, 8'h00, 1'b0, scrf_pkg::FORM_ALIAS);
    c = sb.crc16_step(sb.crc16_step(16'h0000, cur_addr), 8'h00);
    for (int k = 0; k < 5; k++) begin
      d = (k == 4) ? 8'hFF : 8'(8'h11 * (k + 1));
      c = sb.crc16_step(c, d);
      push_item(scrf_pkg::OP_RX, d, 1'b0, scrf_pkg::FORM_TWO);
    end
    push_item(scrf_pkg::OP_RX, c[15:8], 1'b0, scrf_pkg::FORM_TWO);
    push_item(scrf_pkg::OP_RX, c[7:0], 1'b0, scrf_pkg::FORM_TWO);

    // two-byte reply with bad CRC -> resend; then silence -> final failure
    push_item(scrf_pkg::OP_READ, 8'hFF, 1'b1, scrf_pkg::FORM_TWO);
    push_item(scrf_pkg::OP_RX, 8'hFF, 1'b0, scrf_pkg::FORM_TWO);
    push_item(scrf_pkg::OP_RX, 8'h00, 1'b0, scrf_pkg::FORM_TWO);
    push_item(scrf_pkg::OP_RX, 8'h00, 1'b0, scrf_pkg::FORM_TWO);
    push_item(scrf_pkg::OP_RX, 8'h00, 1'b0, scrf_pkg::FORM_TWO);
    push_item(scrf_pkg::OP_TICK, 8'h00, 1'b0, scrf_pkg::FORM_TWO);
    push_item(scrf_pkg::OP_TICK, 8'h00, 1'b0, scrf_pkg::FORM_TWO);
    settle();

    // ---- random phases, each under its own config ----
    for (int ph = 0; ph < 5; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 33;
        recv_idle_pct = 45;
      end else if (ph < 4) begin
        send_idle_pct = 45;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0:       set_config(8'h00, 4'd0, 16'd1);
        1:       set_config(8'hFF, 4'd15, 16'hFFFF);
        2:       set_config(8'($urandom), 4'd3, 16'd0);   // zero timeout: first tick expires
        3:       set_config(8'($urandom), 4'd1, 16'd5);
        default: set_config(8'($urandom), 4'd2, 16'd12);
      endcase
      begin : phase_body
        int start_count;
        start_count = items_sent;
        while (items_sent - start_count < PHASE_ITEMS) random_sequence();
      end
      settle();
    end

    if (sb.due_results.size() != 0) begin
      $error("%0d expected results never arrived", sb.due_results.size());
      sb.fails++;
    end
    if (sb.fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
